// ===== rtl/assert_macros.svh =====
// Assertion macros used by tbpre_back of the envelope RTL.
// Depends on nothing; bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/tbpre_pkg.sv =====
// Types and constants of the three-band peak/RMS envelope.
// Used by every module of the block; depends on nothing.
package tbpre_pkg;
	localparam int SUM_W = 48;
	localparam int LEN_W = 17;
	localparam int MAG_W = 16;
	localparam logic [15:0] BAND_SAT = 16'hFFFF;
	localparam logic [1:0] CFG_BUCKET_LENGTH = 2'd0;
	localparam logic [1:0] CFG_LOW_ALPHA = 2'd1;
	localparam logic [1:0] CFG_HIGH_ALPHA = 2'd2;

	typedef struct packed {
		logic [MAG_W-1:0] peak;
		logic [MAG_W-1:0] bass_peak;
		logic [MAG_W-1:0] mid_peak;
		logic [MAG_W-1:0] treble_peak;
		logic [SUM_W-1:0] square_sum;
		logic [LEN_W+3:0] count;
	} bucket_t;

	typedef struct packed {
		logic [15:0] peak;
		logic [15:0] rms;
		logic [15:0] bass_peak;
		logic [15:0] mid_peak;
		logic [15:0] treble_peak;
	} result_t;
endpackage

// ===== rtl/tbpre_in_if.sv =====
// Sample input stream interface of the envelope block.
// Depends on nothing.
interface tbpre_in_if #(parameter int SAMPLE_WIDTH = 16);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic first_of_track;
	modport source (output valid, output sample, output first_of_track, input ready);
	modport sink (input valid, input sample, input first_of_track, output ready);
endinterface

// ===== rtl/tbpre_out_if.sv =====
// Result stream interface of the envelope block.
// Depends on nothing.
interface tbpre_out_if;
	logic valid;
	logic ready;
	logic [15:0] peak;
	logic [15:0] rms;
	logic [15:0] bass_peak;
	logic [15:0] mid_peak;
	logic [15:0] treble_peak;
	modport source (output valid, output peak, output rms, output bass_peak,
		output mid_peak, output treble_peak, input ready);
	modport sink (input valid, input peak, input rms, input bass_peak,
		input mid_peak, input treble_peak, output ready);
endinterface

// ===== rtl/tbpre_front.sv =====
// Front part: filters, band peaks, square sum and bucket counting.
// Depends on tbpre_pkg.
module tbpre_front import tbpre_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH = 16,
	parameter int MAX_BUCKET = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic first_of_track,
	input  logic [LEN_W-1:0] bucket_length,
	input  logic [COEF_WIDTH-1:0] low_alpha,
	input  logic [COEF_WIDTH-1:0] high_alpha,
	output logic bkt_valid,
	output bucket_t bkt
);
	localparam int LVW = 24;
	localparam int LP_FRAC = LVW - SAMPLE_WIDTH;
	localparam int HP_FRAC = LP_FRAC / 2;
	localparam int PW = LVW + 2 + COEF_WIDTH + 1;
	localparam int CW = LEN_W + 4;
	localparam logic signed [PW-1:0] LMAX = PW'((64'sd1 <<< (LVW - 1)) - 1);
	localparam logic signed [PW-1:0] LMIN = -PW'(64'sd1 <<< (LVW - 1));
	localparam logic [CW-1:0] MAXB = CW'(MAX_BUCKET);

	logic signed [LVW-1:0] lp_q, hp_q;
	logic signed [SAMPLE_WIDTH-1:0] xprev_q;
	logic [CW-1:0] cnt_q;
	logic [MAG_W-1:0] rp_q, bm_q, mm_q, tm_q;
	logic [SUM_W-1:0] ss_q;

	logic signed [LVW-1:0] lp_c, hp_c, lp_n, hp_n;
	logic signed [SAMPLE_WIDTH-1:0] xp_c;
	logic signed [LVW+1:0] d, t;
	logic signed [PW-1:0] lpp, hpp, lsum;
	logic signed [LVW+2:0] bass, treb, mid;
	logic [CW-1:0] cnt_c, cnt_n, len;
	logic [MAG_W-1:0] rp_c, bm_c, mm_c, tm_c, rp_n, bm_n, mm_n, tm_n;
	logic [SUM_W-1:0] ss_c, ss_n;
	logic signed [2*SAMPLE_WIDTH-1:0] sq;
	logic done;

	function automatic logic signed [PW-1:0] clampl(input logic signed [PW-1:0] v);
		if (v > LMAX) return LMAX;
		if (v < LMIN) return LMIN;
		return v;
	endfunction

	function automatic logic [MAG_W-1:0] mag(input logic signed [LVW+2:0] v);
		logic [LVW+2:0] a;
		a = v[LVW+2] ? LVW'(0) - v : v;
		return (a > (LVW+3)'(BAND_SAT)) ? BAND_SAT : a[MAG_W-1:0];
	endfunction

	always_comb begin
		lp_c = first_of_track ? '0 : lp_q;
		hp_c = first_of_track ? '0 : hp_q;
		xp_c = first_of_track ? '0 : xprev_q;
		cnt_c = first_of_track ? '0 : cnt_q;
		rp_c = first_of_track ? '0 : rp_q;
		bm_c = first_of_track ? '0 : bm_q;
		mm_c = first_of_track ? '0 : mm_q;
		tm_c = first_of_track ? '0 : tm_q;
		ss_c = first_of_track ? '0 : ss_q;
		d = (LVW+2)'(sample) * (LVW+2)'(2 ** LP_FRAC) - (LVW+2)'(lp_c);
		lpp = PW'(d) * $signed({1'b0, low_alpha});
		lsum = PW'(lp_c) + (lpp >>> COEF_WIDTH);
		lp_n = LVW'(clampl(lsum));
		t = (LVW+2)'(hp_c) + ((LVW+2)'(sample) - (LVW+2)'(xp_c)) * (LVW+2)'(2 ** HP_FRAC);
		hpp = PW'(t) * $signed({1'b0, high_alpha});
		hp_n = LVW'(clampl(hpp >>> COEF_WIDTH));
		bass = (LVW+3)'(lp_n >>> LP_FRAC);
		treb = (LVW+3)'(hp_n >>> HP_FRAC);
		mid = (LVW+3)'(sample) - bass - treb;
		rp_n = mag((LVW+3)'(sample)) > rp_c ? mag((LVW+3)'(sample)) : rp_c;
		bm_n = mag(bass) > bm_c ? mag(bass) : bm_c;
		mm_n = mag(mid) > mm_c ? mag(mid) : mm_c;
		tm_n = mag(treb) > tm_c ? mag(treb) : tm_c;
		sq = sample * sample;
		ss_n = ss_c + SUM_W'($unsigned(sq));
		cnt_n = cnt_c + CW'(1);
		len = CW'(bucket_length);
		if (len == '0) len = CW'(1);
		if (len > MAXB) len = MAXB;
		done = cnt_n >= len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0; hp_q <= '0; xprev_q <= '0; cnt_q <= '0;
			rp_q <= '0; bm_q <= '0; mm_q <= '0; tm_q <= '0; ss_q <= '0;
			bkt_valid <= 1'b0;
		end else begin
			bkt_valid <= in_fire && done;
			if (in_fire) begin
				lp_q <= lp_n;
				hp_q <= hp_n;
				xprev_q <= sample;
				cnt_q <= done ? '0 : cnt_n;
				rp_q <= done ? '0 : rp_n;
				bm_q <= done ? '0 : bm_n;
				mm_q <= done ? '0 : mm_n;
				tm_q <= done ? '0 : tm_n;
				ss_q <= done ? '0 : ss_n;
				bkt <= '{rp_n, bm_n, mm_n, tm_n, ss_n, cnt_n};
			end
		end
	end
endmodule

// ===== rtl/tbpre_back.sv =====
// Back part: queue of finished buckets, divide, square root, output register.
// Depends on tbpre_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tbpre_back import tbpre_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic bkt_valid,
	input  bucket_t bkt,
	output logic q_room,
	output logic out_valid,
	input  logic out_ready,
	output result_t res
);
	localparam int QD = 2;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	bucket_t q_mem [QD];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [1:0] st_q;
	logic [5:0] step_q;
	logic [SUM_W-1:0] quo_q, rem_q;
	logic [SUM_W-1:0] sr_n_q, sr_res_q, sr_bit_q;
	bucket_t cur_q;
	logic [SUM_W:0] rtry;
	logic [SUM_W-1:0] sr_t;
	logic push, pop;

	assign q_room = (cnt_q == 2'd0);
	assign push = bkt_valid;
	assign pop = (st_q == ST_IDLE) && (cnt_q != 2'd0);
	assign out_valid = (st_q == ST_OUT);
	assign rtry = {rem_q, quo_q[SUM_W-1]};
	assign sr_t = sr_res_q + sr_bit_q;

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= bkt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; st_q <= ST_IDLE; step_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			unique case (st_q)
				ST_IDLE: begin
					if (pop) begin
						cur_q <= q_mem[rp_q];
						quo_q <= q_mem[rp_q].square_sum;
						rem_q <= '0;
						step_q <= '0;
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if ((SUM_W+1)'(rtry) >= (SUM_W+1)'(cur_q.count)) begin
						rem_q <= SUM_W'(rtry - (SUM_W+1)'(cur_q.count));
						quo_q <= {quo_q[SUM_W-2:0], 1'b1};
					end else begin
						rem_q <= SUM_W'(rtry);
						quo_q <= {quo_q[SUM_W-2:0], 1'b0};
					end
					step_q <= step_q + 6'd1;
					if (step_q == 6'(SUM_W - 1)) begin
						st_q <= ST_SQRT;
						step_q <= '0;
					end
				end
				ST_SQRT: begin
					if (step_q == 6'd0) begin
						sr_n_q <= quo_q;
						sr_res_q <= '0;
						sr_bit_q <= SUM_W'(1) << (SUM_W - 2);
						step_q <= 6'd1;
					end else if (sr_bit_q == '0) begin
						st_q <= ST_OUT;
					end else begin
						if (sr_n_q >= sr_t) begin
							sr_n_q <= sr_n_q - sr_t;
							sr_res_q <= (sr_res_q >> 1) + sr_bit_q;
						end else begin
							sr_res_q <= sr_res_q >> 1;
						end
						sr_bit_q <= sr_bit_q >> 2;
					end
				end
				ST_OUT: begin
					if (out_ready) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign res.peak = cur_q.peak;
	assign res.rms = (sr_res_q > SUM_W'(16'hFFFF)) ? 16'hFFFF : sr_res_q[15:0];
	assign res.bass_peak = cur_q.bass_peak;
	assign res.mid_peak = cur_q.mid_peak;
	assign res.treble_peak = cur_q.treble_peak;

	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push, cnt_q != 2'd2 || pop)
	`ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && !out_ready, out_valid)
	`ASSERT_IMPLIES(a_div_nonzero, clk, arst_n, st_q == ST_DIV, cur_q.count != '0)
endmodule

// ===== rtl/three_band_peak_rms_envelope_top.sv =====
// Top level of the three-band peak/RMS envelope.
// Depends on tbpre_pkg, the stream interfaces, tbpre_front and tbpre_back.
//
// Samples enter on in_ch (sample, first_of_track); a result leaves on out_ch
// after every bucket_length samples. Registers are written through cfg_we,
// cfg_index, cfg_data: 0 bucket_length, 1 low_alpha, 2 high_alpha. The user
// must write them only while the block is idle; the block does not enforce it.
// The front part takes one sample per cycle while in_ch.ready is high:
// filters, band peaks, square sum and bucket count update combinationally
// and are registered on each accepted sample. A finished bucket enters a
// two-entry queue; the back part divides the square sum by the count (one
// quotient bit a cycle), takes the square root and then presents the result.
// Input pauses while a bucket moves into the queue and while one waits
// there, until the back part takes it, which it does only when idle, after
// the previous result has been accepted.
// Reset clears filters, bucket and queue and reloads the register defaults.
// A stalled receiver holds the result; the next bucket then waits in the queue and input stops.
module three_band_peak_rms_envelope_top import tbpre_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH = 16,
	parameter int MAX_BUCKET = 65536
) (
	input  logic clk,
	input  logic arst_n,
	tbpre_in_if.sink in_ch,
	tbpre_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [LEN_W-1:0] cfg_data
);
	logic [LEN_W-1:0] len_q;
	logic [COEF_WIDTH-1:0] la_q, ha_q;
	logic room, bkt_valid, in_fire;
	bucket_t bkt;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1024);
			la_q <= COEF_WIDTH'(2253);
			ha_q <= COEF_WIDTH'(41752);
		end else if (cfg_we) begin
			if (cfg_index == CFG_BUCKET_LENGTH) len_q <= cfg_data;
			if (cfg_index == CFG_LOW_ALPHA) la_q <= COEF_WIDTH'(cfg_data);
			if (cfg_index == CFG_HIGH_ALPHA) ha_q <= COEF_WIDTH'(cfg_data);
		end
	end

	assign in_ch.ready = room && !bkt_valid;
	assign in_fire = in_ch.valid && in_ch.ready;

	tbpre_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH),
		.MAX_BUCKET(MAX_BUCKET)) u_front (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .sample(in_ch.sample),
		.first_of_track(in_ch.first_of_track), .bucket_length(len_q),
		.low_alpha(la_q), .high_alpha(ha_q), .bkt_valid(bkt_valid), .bkt(bkt));

	tbpre_back u_back (
		.clk(clk), .arst_n(arst_n), .bkt_valid(bkt_valid), .bkt(bkt),
		.q_room(room), .out_valid(out_ch.valid), .out_ready(out_ch.ready), .res(res));

	assign out_ch.peak = res.peak;
	assign out_ch.rms = res.rms;
	assign out_ch.bass_peak = res.bass_peak;
	assign out_ch.mid_peak = res.mid_peak;
	assign out_ch.treble_peak = res.treble_peak;
endmodule
